// ----- hw/rtl/quaternion_to_euler_angles_core_defines.svh -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - assertion macros
// Clocked property checks used by the core.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// check a property on every rising edge outside reset
`define QTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - package
// Shared constants: arctangent table, threshold reset, inverse gain, pi, register codes.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int THR_W   = 29;
    localparam int ZW      = 34;
    localparam int TAB_LEN = 24;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int GAIN_W  = 30;

    localparam logic [THR_W-1:0]       THR_RESET = 29'd268435188;
    localparam logic [GAIN_W-1:0]      INV_GAIN  = 30'd652032874;
    localparam logic signed [ZW-1:0]   PI_ACC    = 34'sh0_8000_0000;

    localparam logic REG_GIMBAL_THR = 1'b0;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85039060;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/qte_delay.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - delay line
// Fixed-length shift line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module qte_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_d [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_q = r_d[D-1];
endmodule

// ----- hw/rtl/qte_matrix.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - rotation matrix terms
// Three stages: products, matrix sums, singularity test and gimbal product.
// ----------------------------------------------------------------------------
module qte_matrix #(
    parameter int C = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [C-1:0]          i_w,
    input  logic signed [C-1:0]          i_x,
    input  logic signed [C-1:0]          i_y,
    input  logic signed [C-1:0]          i_z,
    input  logic [qte_pkg::THR_W-1:0]    i_thr,
    output logic                         o_vld,
    output logic                         o_gimbal,
    output logic signed [2*C+1:0]        o_r11,
    output logic signed [2*C+1:0]        o_r21,
    output logic signed [2*C+1:0]        o_r33,
    output logic signed [2*C+1:0]        o_r32,
    output logic signed [2*C+1:0]        o_r31,
    output logic signed [2*C+1:0]        o_r12,
    output logic signed [2*C+7:0]        o_prod
);
    import qte_pkg::*;

    localparam int R  = 2*C + 2;
    localparam int H  = R - (C - 2);
    localparam int PW = 2*H;

    logic signed [2*C-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic                  r_v1, r_v2, r_v3;
    logic signed [R-1:0]   r_r11, r_r21, r_r33, r_r32, r_r31, r_r12, r_r13;
    logic signed [R-1:0]   r_s3_r11, r_s3_r21, r_s3_r33, r_s3_r32, r_s3_r31, r_s3_r12;
    logic signed [PW-1:0]  r_prod;
    logic                  r_gimbal;
    logic [R-1:0]          a31;
    logic signed [H-1:0]   s31, s13;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r11 <= R'(r_ww) + R'(r_xx) - R'(r_yy) - R'(r_zz);
            r_r33 <= R'(r_ww) - R'(r_xx) - R'(r_yy) + R'(r_zz);
            r_r21 <= (R'(r_xy) + R'(r_wz)) <<< 1;
            r_r31 <= (R'(r_xz) - R'(r_wy)) <<< 1;
            r_r32 <= (R'(r_yz) + R'(r_wx)) <<< 1;
            r_r12 <= (R'(r_xy) - R'(r_wz)) <<< 1;
            r_r13 <= (R'(r_xz) + R'(r_wy)) <<< 1;
        end
    end

    always_comb begin
        a31 = r_r31[R-1] ? R'(-r_r31) : R'(r_r31);
        s31 = H'(r_r31 >>> (C - 2));
        s13 = H'(r_r13 >>> (C - 2));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gimbal <= {{THR_W{1'b0}}, a31} > {{R{1'b0}}, i_thr};
            r_prod   <= PW'(s31) * PW'(s13);
            r_s3_r11 <= r_r11;
            r_s3_r21 <= r_r21;
            r_s3_r33 <= r_r33;
            r_s3_r32 <= r_r32;
            r_s3_r31 <= r_r31;
            r_s3_r12 <= r_r12;
        end
    end

    assign o_vld    = r_v3;
    assign o_gimbal = r_gimbal;
    assign o_r11    = r_s3_r11;
    assign o_r21    = r_s3_r21;
    assign o_r33    = r_s3_r33;
    assign o_r32    = r_s3_r32;
    assign o_r31    = r_s3_r31;
    assign o_r12    = r_s3_r12;
    assign o_prod   = r_prod;
endmodule

// ----- hw/rtl/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - vectoring CORDIC
// Pre-rotation stage, one register stage per iteration, rounding stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STAGES = 16,
    parameter int W      = 44,
    parameter int AB     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output logic                o_vld,
    output logic signed [W-1:0] o_x,
    output logic [AB-1:0]       o_ang
);
    import qte_pkg::*;

    localparam logic signed [ZW-1:0] RND = ZW'(64'd1 << (31 - AB));

    logic signed [W-1:0]  r_x [0:STAGES];
    logic signed [W-1:0]  r_y [0:STAGES];
    logic signed [ZW-1:0] r_z [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic                 r_v [0:STAGES];
    logic                 r_vo;
    logic signed [W-1:0]  r_xo;
    logic [AB-1:0]        r_ang;
    logic signed [ZW-1:0] z_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[W-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= i_y[W-1] ? -PI_ACC : PI_ACC;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_entry(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_entry(i);
                end
            end
        end
    end

    assign z_sum = r_z[STAGES] + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xo  <= r_x[STAGES];
            r_ang <= r_zero[STAGES] ? '0 : z_sum[31:32-AB];
        end
    end

    assign o_vld = r_vo;
    assign o_x   = r_xo;
    assign o_ang = r_ang;
endmodule

// ----- hw/rtl/qte_mag.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - magnitude scaling
// Remove CORDIC gain from the final x in two stages of partial products.
// ----------------------------------------------------------------------------
module qte_mag #(
    parameter int W = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [W-1:0] i_x,
    output logic                o_vld,
    output logic signed [W-1:0] o_mag
);
    import qte_pkg::*;

    localparam int HW = W - 16;
    localparam int PW = HW + GAIN_W + 1;

    logic [W-1:0]        u;
    logic [HW+GAIN_W-1:0] r_ph;
    logic [GAIN_W-1:0]    r_pl;
    logic [PW-1:0]        p;
    logic [15+GAIN_W:0]   pl_full;
    logic                 r_v1, r_v2;
    logic signed [W-1:0]  r_mag;

    assign u       = i_x[W-1] ? '0 : i_x;
    assign pl_full = u[15:0] * INV_GAIN;
    assign p       = PW'(r_ph) + PW'(r_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph  <= u[W-1:16] * INV_GAIN;
            r_pl  <= pl_full[15+GAIN_W:16];
            r_mag <= p[W+13:14];
        end
    end

    assign o_vld = r_v2;
    assign o_mag = r_mag;
endmodule

// ----- hw/rtl/quaternion_to_euler_angles_core.sv -----
// Throughput: one item per cycle; the unrolled CORDIC pipelines and matrix
// stages each hold one item per register stage, stalled as a whole by o_m side.
// Reset: synchronous, active low; clears valid bits and sets gimbal_threshold
// to 268435188. No clearing pass.
// ----------------------------------------------------------------------------
// Quaternion to Euler angles core
// Unit quaternion in, roll, pitch and yaw binary angles out, with gimbal flag.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_core_defines.svh"

module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES  = 16,
    parameter int ANGLE_BITS     = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // quat_w, quat_x, quat_y, quat_z
    input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0]      i_s_tdata,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // roll_angle, pitch_angle, yaw_angle
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]          o_m_tdata,
    // gimbal_lock
    output logic                                       o_m_tuser,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    input  logic                                       i_psel,
    input  logic                                       i_penable,
    input  logic                                       i_pwrite,
    input  logic [qte_pkg::PADDR_W-1:0]                i_paddr,
    input  logic [qte_pkg::PDATA_W-1:0]                i_pwdata,
    output logic [qte_pkg::PDATA_W-1:0]                o_prdata,
    output logic                                       o_pready
);
    import qte_pkg::*;

    localparam int C     = COMPONENT_BITS;
    localparam int AB    = ANGLE_BITS;
    localparam int R     = 2*C + 2;
    localparam int PW    = 2*C + 8;
    localparam int CW    = 2*C + 12;
    localparam int L     = CORDIC_STAGES + 2;
    localparam int OUT_W = ((3*AB+7)/8)*8;
    localparam logic [AB-1:0] QTR = AB'(64'd1 << (AB - 2));

    logic                 en;
    logic [THR_W-1:0]     r_thr;
    logic                 cfg_wr;

    logic                 m_vld, m_gimbal;
    logic signed [R-1:0]  m_r11, m_r21, m_r33, m_r32, m_r31, m_r12;
    logic signed [PW-1:0] m_prod;

    logic signed [CW-1:0] roll_x, roll_y;
    logic                 roll_vld, pitch_vld;
    logic signed [CW-1:0] roll_xo, pitch_xo;
    logic [AB-1:0]        roll_ang, pitch_ang;

    logic                 mag_vld;
    logic signed [CW-1:0] mag;
    logic signed [R-1:0]  r31_d;

    logic                 yaw_vld;
    logic signed [CW-1:0] yaw_xo;
    logic [AB-1:0]        yaw_ang;
    logic [AB-1:0]        roll_d, pitch_d;
    logic [1:0]           side_d;

    logic                 r_out_vld;
    logic                 r_out_user;
    logic [OUT_W-1:0]     r_out_data;
    logic [OUT_W-1:0]     n_out_data;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // configuration
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (cfg_wr && (i_paddr[2] == REG_GIMBAL_THR)) begin
            r_thr <= i_pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_GIMBAL_THR) begin
            o_prdata[THR_W-1:0] = r_thr;
        end
    end

    qte_matrix #(.C(C)) u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_tvalid),
        .i_w      (i_s_tdata[C-1:0]),
        .i_x      (i_s_tdata[2*C-1:C]),
        .i_y      (i_s_tdata[3*C-1:2*C]),
        .i_z      (i_s_tdata[4*C-1:3*C]),
        .i_thr    (r_thr),
        .o_vld    (m_vld),
        .o_gimbal (m_gimbal),
        .o_r11    (m_r11),
        .o_r21    (m_r21),
        .o_r33    (m_r33),
        .o_r32    (m_r32),
        .o_r31    (m_r31),
        .o_r12    (m_r12),
        .o_prod   (m_prod)
    );

    assign roll_x = m_gimbal ? -CW'(m_prod) : CW'(m_r11);
    assign roll_y = m_gimbal ? -CW'(m_r12)  : CW'(m_r21);

    qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .AB(AB)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (m_vld),
        .i_x     (roll_x),
        .i_y     (roll_y),
        .o_vld   (roll_vld),
        .o_x     (roll_xo),
        .o_ang   (roll_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .AB(AB)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (m_vld),
        .i_x     (CW'(m_r33)),
        .i_y     (CW'(m_r32)),
        .o_vld   (pitch_vld),
        .o_x     (pitch_xo),
        .o_ang   (pitch_ang)
    );

    qte_mag #(.W(CW)) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (roll_vld),
        .i_x     (roll_xo),
        .o_vld   (mag_vld),
        .o_mag   (mag)
    );

    qte_delay #(.W(R), .D(L + 2)) u_dly_r31 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (m_r31),
        .o_q   (r31_d)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .AB(AB)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mag_vld),
        .i_x     (mag),
        .i_y     (-CW'(r31_d)),
        .o_vld   (yaw_vld),
        .o_x     (yaw_xo),
        .o_ang   (yaw_ang)
    );

    qte_delay #(.W(AB), .D(L + 2)) u_dly_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (roll_ang),
        .o_q   (roll_d)
    );

    qte_delay #(.W(AB), .D(L + 2)) u_dly_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (pitch_ang),
        .o_q   (pitch_d)
    );

    qte_delay #(.W(2), .D(2*L + 2)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({m_gimbal, m_r31[R-1]}),
        .o_q   (side_d)
    );

    always_comb begin
        n_out_data = '0;
        n_out_data[AB-1:0] = roll_d;
        if (side_d[1]) begin
            n_out_data[3*AB-1:2*AB] = side_d[0] ? QTR : -QTR;
        end else begin
            n_out_data[2*AB-1:AB]   = pitch_d;
            n_out_data[3*AB-1:2*AB] = yaw_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= yaw_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_user <= side_d[1];
        end
    end

    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tvalid = r_out_vld;

    `QTE_ASSERT(a_gimbal_pitch_zero, o_m_tvalid && o_m_tuser |-> o_m_tdata[2*AB-1:AB] == '0, "gimbal item with nonzero pitch")
    `QTE_ASSERT(a_gimbal_yaw_quarter, o_m_tvalid && o_m_tuser |-> (o_m_tdata[3*AB-1:2*AB] == QTR) || (o_m_tdata[3*AB-1:2*AB] == AB'(-QTR)), "gimbal yaw not a quarter turn")
    `QTE_ASSERT_ALWAYS(a_ready_when_empty, !o_m_tvalid |-> o_s_tready, "input stalled with empty output")
endmodule
